// File: rtl/sgb_pkg.sv
// Shared constants, codes and arithmetic helpers for the separable Gaussian blur.
// Used by the top level separable_gaussian_blur; no dependencies.
`default_nettype none

package sgb_pkg;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;
    localparam int DEF_MAX_RADIUS = 7;

    localparam int IN_DATA_W   = 32;
    localparam int IN_USER_W   = 2;
    localparam int OUT_DATA_W  = 16;
    localparam int OUT_USER_W  = 1;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;

    localparam int DIM_W  = 9;
    localparam int RAD_W  = 3;
    localparam int PIX_W  = 16;
    localparam int TAP_W  = 16;
    localparam int PROD_W = 32;
    localparam int ACC_W  = 36;
    localparam int SUM_W  = ACC_W + 1;

    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_RUN  = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_WIDTH  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEIGHT = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_RADIUS = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_COEF_LO = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_COEF_HI = 3'd4;

    localparam logic KIND_DONE = 1'b0;
    localparam logic KIND_READ = 1'b1;

    function automatic logic [TAP_W-1:0] tap_select(
        input logic [CFG_DATA_W-1:0] coef_lo,
        input logic [CFG_DATA_W-1:0] coef_hi,
        input logic [RAD_W-1:0]      idx
    );
        logic [5:0] bit_pos;
        bit_pos = {idx[1:0], 4'b0000};
        if (idx[2]) begin
            return coef_hi[bit_pos +: TAP_W];
        end else begin
            return coef_lo[bit_pos +: TAP_W];
        end
    endfunction

    function automatic logic [PIX_W-1:0] round_sat(input logic [ACC_W-1:0] acc);
        logic [SUM_W-1:0]  sum;
        logic [ACC_W-16:0] val;
        sum = {1'b0, acc} + SUM_W'(32'h8000);
        val = sum[SUM_W-1:16];
        if (val > (ACC_W-15)'(32'hFFFF)) begin
            return 16'hFFFF;
        end else begin
            return val[PIX_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

// File: rtl/separable_gaussian_blur.sv
// Top level of the separable Gaussian blur with clamp-to-edge borders.
// Depends on sgb_pkg and on sgb_ram for the frame and column pass stores.
//
// Usage: commands arrive on the s_ stream, tuser carrying the opcode. A load
// inside the frame writes one pixel into the frame store and returns nothing. A
// read returns the stored pixel on the m_ stream (tuser 1), passing through the
// S_READ_WAIT and S_RESULT states into the output register. A run filters the
// whole frame, vertical pass into the column store, then horizontal pass back
// into the frame store, and ends with one result of kind 0 and data zero.
// Each tap of a run passes through S_TAP_ADDR, S_TAP_MUL and S_TAP_ACC: one store
// read, one multiply and one accumulate in the single shared multiply-accumulate
// unit; each pixel then takes one write-back in S_STORE. s_tready is low for the
// whole run and, after a read, until the result is moved into the output register.
// Configuration writes on the cfg_ channel are always accepted and are meant to
// happen while the block is idle. Reset restores 256 x 256, radius 4 and zero
// taps; the stores are not cleared and hold unknown data until loaded.
// A result waits in the output register while the receiver stalls; loads keep
// being accepted meanwhile, and a further read or run is still accepted, after
// which s_tready stays low until the waiting result is taken.
`default_nettype none

module separable_gaussian_blur #(
    parameter int MAX_WIDTH  = sgb_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = sgb_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_RADIUS = sgb_pkg::DEF_MAX_RADIUS
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // pixel_column [7:0], pixel_row [15:8], pixel_value [31:16]
    input  wire logic [sgb_pkg::IN_DATA_W-1:0]    s_tdata,
    // opcode [1:0]
    input  wire logic [sgb_pkg::IN_USER_W-1:0]    s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // filtered_value [15:0]
    output logic      [sgb_pkg::OUT_DATA_W-1:0]   m_tdata,
    // result_kind [0]
    output logic      [sgb_pkg::OUT_USER_W-1:0]   m_tuser,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [sgb_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [sgb_pkg::CFG_DATA_W-1:0]   cfg_data
);

    import sgb_pkg::*;

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int MW = (XW > YW) ? XW : YW;
    localparam int CW = MW + 2;
    localparam int AW = XW + YW;
    localparam int DEPTH = 2 ** AW;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ_WAIT,
        S_TAP_ADDR,
        S_TAP_MUL,
        S_TAP_ACC,
        S_STORE,
        S_RESULT
    } state_t;

    state_t                  state_reg;
    logic [DIM_W-1:0]        width_reg;
    logic [DIM_W-1:0]        height_reg;
    logic [RAD_W-1:0]        radius_reg;
    logic [CFG_DATA_W-1:0]   coef_lo_reg;
    logic [CFG_DATA_W-1:0]   coef_hi_reg;

    logic [XW-1:0]           x_reg;
    logic [YW-1:0]           y_reg;
    logic                    pass_reg;
    logic signed [RAD_W:0]   k_reg;
    logic [TAP_W-1:0]        tap_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic [ACC_W-1:0]        acc_reg;
    logic [PIX_W-1:0]        res_val_reg;
    logic                    res_kind_reg;
    logic                    m_tvalid_reg;
    logic [OUT_DATA_W-1:0]   m_tdata_reg;
    logic [OUT_USER_W-1:0]   m_tuser_reg;

    logic [1:0]              in_opcode;
    logic [7:0]              in_col;
    logic [7:0]              in_row;
    logic [PIX_W-1:0]        in_val;
    logic                    s_accept;
    logic                    col_ok;
    logic                    row_ok;
    logic [XW-1:0]           last_col;
    logic [YW-1:0]           last_row;
    logic [RAD_W-1:0]        eff_radius;
    logic signed [RAD_W:0]   k_last;
    logic signed [RAD_W:0]   k_first;
    logic [RAD_W-1:0]        k_abs;
    logic [AW-1:0]           load_addr;
    logic [AW-1:0]           read_addr;
    logic [AW-1:0]           store_addr;
    logic [AW-1:0]           tap_addr;
    logic [MW-1:0]           center;
    logic [MW-1:0]           last_line;
    logic signed [CW-1:0]    pos;
    logic [MW-1:0]           clamped;
    logic [PIX_W-1:0]        sat_val;

    logic                    frame_we;
    logic [AW-1:0]           frame_waddr;
    logic [PIX_W-1:0]        frame_wdata;
    logic [AW-1:0]           frame_raddr;
    logic [PIX_W-1:0]        frame_rdata;
    logic                    col_we;
    logic [PIX_W-1:0]        col_rdata;
    logic [PIX_W-1:0]        tap_rdata;

    assign in_opcode = s_tuser[1:0];
    assign in_col    = s_tdata[7:0];
    assign in_row    = s_tdata[15:8];
    assign in_val    = s_tdata[31:16];
    assign s_tready  = (state_reg == S_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    always_comb begin
        if (width_reg == '0) begin
            last_col = '0;
        end else if (32'(width_reg) > MAX_WIDTH) begin
            last_col = XW'(MAX_WIDTH - 1);
        end else begin
            last_col = XW'(width_reg - 9'd1);
        end
        if (height_reg == '0) begin
            last_row = '0;
        end else if (32'(height_reg) > MAX_HEIGHT) begin
            last_row = YW'(MAX_HEIGHT - 1);
        end else begin
            last_row = YW'(height_reg - 9'd1);
        end
        if (32'(radius_reg) > MAX_RADIUS) begin
            eff_radius = RAD_W'(MAX_RADIUS);
        end else begin
            eff_radius = radius_reg;
        end
    end

    assign k_last  = $signed({1'b0, eff_radius});
    assign k_first = -k_last;
    assign k_abs   = k_reg[RAD_W] ? RAD_W'(-k_reg) : k_reg[RAD_W-1:0];

    assign col_ok    = 32'(in_col) <= 32'(last_col);
    assign row_ok    = 32'(in_row) <= 32'(last_row);
    assign load_addr = {YW'(in_row), XW'(in_col)};
    assign read_addr = {row_ok ? YW'(in_row) : last_row, col_ok ? XW'(in_col) : last_col};
    assign store_addr = {y_reg, x_reg};

    always_comb begin
        center    = pass_reg ? MW'(x_reg) : MW'(y_reg);
        last_line = pass_reg ? MW'(last_col) : MW'(last_row);
        pos       = $signed(CW'(center)) + CW'(k_reg);
        if (pos < 0) begin
            clamped = '0;
        end else if (pos > $signed(CW'(last_line))) begin
            clamped = last_line;
        end else begin
            clamped = MW'(pos);
        end
        tap_addr = pass_reg ? {y_reg, XW'(clamped)} : {YW'(clamped), x_reg};
    end

    assign sat_val   = round_sat(acc_reg);
    assign tap_rdata = pass_reg ? col_rdata : frame_rdata;

    assign frame_we    = (s_accept && (in_opcode == OP_LOAD) && col_ok && row_ok)
                       || ((state_reg == S_STORE) && pass_reg);
    assign frame_waddr = (state_reg == S_STORE) ? store_addr : load_addr;
    assign frame_wdata = (state_reg == S_STORE) ? sat_val : in_val;
    assign frame_raddr = (state_reg == S_IDLE) ? read_addr : tap_addr;
    assign col_we      = (state_reg == S_STORE) && !pass_reg;

    sgb_ram #(
        .DATA_W(PIX_W),
        .DEPTH (DEPTH)
    ) u_frame_ram (
        .aclk (aclk),
        .we   (frame_we),
        .waddr(frame_waddr),
        .wdata(frame_wdata),
        .raddr(frame_raddr),
        .rdata(frame_rdata)
    );

    sgb_ram #(
        .DATA_W(PIX_W),
        .DEPTH (DEPTH)
    ) u_column_ram (
        .aclk (aclk),
        .we   (col_we),
        .waddr(store_addr),
        .wdata(sat_val),
        .raddr(tap_addr),
        .rdata(col_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   <= DIM_W'(256);
            height_reg  <= DIM_W'(256);
            radius_reg  <= RAD_W'(4);
            coef_lo_reg <= '0;
            coef_hi_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_WIDTH:   width_reg   <= cfg_data[DIM_W-1:0];
                CFG_HEIGHT:  height_reg  <= cfg_data[DIM_W-1:0];
                CFG_RADIUS:  radius_reg  <= cfg_data[RAD_W-1:0];
                CFG_COEF_LO: coef_lo_reg <= cfg_data;
                CFG_COEF_HI: coef_hi_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready && (state_reg != S_RESULT)) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_accept && (in_opcode == OP_RUN)) begin
                        x_reg     <= '0;
                        y_reg     <= '0;
                        pass_reg  <= 1'b0;
                        k_reg     <= k_first;
                        acc_reg   <= '0;
                        state_reg <= S_TAP_ADDR;
                    end else if (s_accept && (in_opcode == OP_READ)) begin
                        state_reg <= S_READ_WAIT;
                    end
                end
                S_READ_WAIT: begin
                    res_val_reg  <= frame_rdata;
                    res_kind_reg <= KIND_READ;
                    state_reg    <= S_RESULT;
                end
                S_TAP_ADDR: begin
                    tap_reg   <= tap_select(coef_lo_reg, coef_hi_reg, k_abs);
                    state_reg <= S_TAP_MUL;
                end
                S_TAP_MUL: begin
                    prod_reg  <= PROD_W'(tap_rdata) * PROD_W'(tap_reg);
                    state_reg <= S_TAP_ACC;
                end
                S_TAP_ACC: begin
                    acc_reg <= acc_reg + ACC_W'(prod_reg);
                    if (k_reg == k_last) begin
                        state_reg <= S_STORE;
                    end else begin
                        k_reg     <= k_reg + 4'sd1;
                        state_reg <= S_TAP_ADDR;
                    end
                end
                S_STORE: begin
                    acc_reg   <= '0;
                    k_reg     <= k_first;
                    state_reg <= S_TAP_ADDR;
                    if (y_reg == last_row) begin
                        y_reg <= '0;
                        if (x_reg == last_col) begin
                            x_reg <= '0;
                            if (pass_reg) begin
                                res_val_reg  <= '0;
                                res_kind_reg <= KIND_DONE;
                                state_reg    <= S_RESULT;
                            end else begin
                                pass_reg <= 1'b1;
                            end
                        end else begin
                            x_reg <= x_reg + XW'(1);
                        end
                    end else begin
                        y_reg <= y_reg + YW'(1);
                    end
                end
                S_RESULT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= res_val_reg;
                        m_tuser_reg  <= res_kind_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // The two stores are never written in the same cycle.
    a_single_store_write: assert property (@(posedge aclk) disable iff (!aresetn)
        !(frame_we && col_we))
        else $error("frame and column stores written together");

    // A run transfer holds off the input side on the following cycle.
    a_run_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && (in_opcode == OP_RUN)) |=> !s_tready)
        else $error("input accepted right after a run transfer");

    // The clamped tap coordinate stays inside the frame.
    a_tap_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_TAP_ADDR) |-> (clamped <= last_line))
        else $error("tap coordinate outside the frame");

    // A finished-run result carries zero data.
    a_done_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == S_RESULT) && (res_kind_reg == KIND_DONE)) |-> (res_val_reg == '0))
        else $error("run result with nonzero data");

    // The output register is only loaded while empty or being drained.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tready && (state_reg == S_RESULT)) |=> (state_reg == S_RESULT))
        else $error("pending result overwritten");

endmodule

`default_nettype wire

// File: rtl/sgb_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; used for the frame store and the column pass store.
`default_nettype none

module sgb_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 256,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: verif/tb_top.sv
// Self-checking testbench for separable_gaussian_blur: loads frames, runs both blur passes
// and reads pixels back, predicting every result with a local model of the two passes.
// Depends on sgb_pkg and on the RTL of separable_gaussian_blur.
`default_nettype none

module tb_top;
    import sgb_pkg::*;

    localparam int CLK_PERIOD       = 8;
    localparam int TIMEOUT_CYCLES   = 3_000_000;
    localparam int ITEM_TARGET      = 1850;
    localparam int SETTLE_CYCLES    = 8;
    localparam int LONG_HOLD_CYCLES = 500;
    localparam int RADIUS_TOP       = DEF_MAX_RADIUS;
    localparam int FRAME_STRIDE     = DEF_MAX_WIDTH;

    localparam logic [1:0]             OP_UNUSED    = 2'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNMAPPED = 3'd5;

    typedef enum int {
        KERNEL_SMOOTH,
        KERNEL_RANDOM,
        KERNEL_FULL,
        KERNEL_ZERO
    } kernel_style_t;

    typedef struct packed {
        logic              kind;
        logic [PIX_W-1:0]  value;
    } blur_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_DATA_W-1:0] s_tdata = '0;
    logic [IN_USER_W-1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [OUT_USER_W-1:0] m_tuser;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    separable_gaussian_blur u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    logic [PIX_W-1:0] frame_model [0:DEF_MAX_WIDTH*DEF_MAX_HEIGHT-1];
    logic [PIX_W-1:0] column_model [0:DEF_MAX_WIDTH*DEF_MAX_HEIGHT-1];
    logic [DIM_W-1:0] width_reg = 9'd256;
    logic [DIM_W-1:0] height_reg = 9'd256;
    logic [RAD_W-1:0] radius_reg = 3'd4;
    logic [CFG_DATA_W-1:0] taps_lo = '0;
    logic [CFG_DATA_W-1:0] taps_hi = '0;

    blur_result_t awaited_results[$];
    blur_result_t oldest_result;

    int fail_count = 0;
    int results_checked = 0;
    int effective_items = 0;
    int runs_sent = 0;
    int reads_sent = 0;
    int loads_sent = 0;
    int burst_left = 0;
    int hold_requests = 0;
    int holds_served = 0;
    int hold_left = 0;
    int stall_left = 0;
    int stall_mode = 0;

    function automatic int active_width();
        if (width_reg == 0) begin
            return 1;
        end
        if (width_reg > FRAME_STRIDE) begin
            return FRAME_STRIDE;
        end
        return int'(width_reg);
    endfunction

    function automatic int active_height();
        if (height_reg == 0) begin
            return 1;
        end
        if (height_reg > DEF_MAX_HEIGHT) begin
            return DEF_MAX_HEIGHT;
        end
        return int'(height_reg);
    endfunction

    function automatic logic [TAP_W-1:0] tap_at(input int k);
        int m;
        m = (k < 0) ? -k : k;
        if (m < 4) begin
            return taps_lo[16*m +: 16];
        end
        return taps_hi[16*(m-4) +: 16];
    endfunction

    function automatic logic [PIX_W-1:0] round_to_pixel(input logic [63:0] acc);
        logic [63:0] v;
        v = (acc + 64'h8000) >> 16;
        return (v > 64'hFFFF) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic void blur_frame();
        int w, h, rad, x, y, k, idx;
        logic [63:0] acc;
        w = active_width();
        h = active_height();
        rad = int'(radius_reg);
        for (x = 0; x < w; x++) begin
            for (y = 0; y < h; y++) begin
                acc = '0;
                for (k = -rad; k <= rad; k++) begin
                    idx = y + k;
                    idx = (idx < 0) ? 0 : ((idx > h - 1) ? h - 1 : idx);
                    acc += 64'(frame_model[idx*FRAME_STRIDE + x]) * 64'(tap_at(k));
                end
                column_model[y*FRAME_STRIDE + x] = round_to_pixel(acc);
            end
        end
        for (x = 0; x < w; x++) begin
            for (y = 0; y < h; y++) begin
                acc = '0;
                for (k = -rad; k <= rad; k++) begin
                    idx = x + k;
                    idx = (idx < 0) ? 0 : ((idx > w - 1) ? w - 1 : idx);
                    acc += 64'(column_model[y*FRAME_STRIDE + idx]) * 64'(tap_at(k));
                end
                frame_model[y*FRAME_STRIDE + x] = round_to_pixel(acc);
            end
        end
    endfunction

    function automatic void predict_command(input logic [1:0] op, input logic [7:0] col,
                                            input logic [7:0] row, input logic [15:0] value);
        int w, h, c, r;
        blur_result_t res;
        w = active_width();
        h = active_height();
        case (op)
            OP_LOAD: begin
                if (int'(col) < w && int'(row) < h) begin
                    frame_model[int'(row)*FRAME_STRIDE + int'(col)] = value;
                    effective_items++;
                    loads_sent++;
                end
            end
            OP_RUN: begin
                blur_frame();
                res.kind = KIND_DONE;
                res.value = '0;
                awaited_results.push_back(res);
                effective_items++;
                runs_sent++;
            end
            OP_READ: begin
                c = (int'(col) > w - 1) ? w - 1 : int'(col);
                r = (int'(row) > h - 1) ? h - 1 : int'(row);
                res.kind = KIND_READ;
                res.value = frame_model[r*FRAME_STRIDE + c];
                awaited_results.push_back(res);
                effective_items++;
                reads_sent++;
            end
            default: begin
            end
        endcase
    endfunction

    task automatic send_command(input logic [1:0] op, input logic [7:0] col,
                                input logic [7:0] row, input logic [15:0] value);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        burst_left--;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {value, row, col};
        do @(posedge aclk); while (!s_tready);
        predict_command(op, col, row, value);
    endtask

    task automatic wait_drained(input int settle);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (awaited_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (settle) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (index)
            CFG_WIDTH:   width_reg = data[DIM_W-1:0];
            CFG_HEIGHT:  height_reg = data[DIM_W-1:0];
            CFG_RADIUS:  radius_reg = data[RAD_W-1:0];
            CFG_COEF_LO: taps_lo = data;
            CFG_COEF_HI: taps_hi = data;
            default: begin
            end
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_dim(input logic [CFG_INDEX_W-1:0] index, input int dim);
        logic [CFG_DATA_W-1:0] data;
        data = {$urandom, $urandom};
        data[DIM_W-1:0] = dim[DIM_W-1:0];
        write_reg(index, data);
    endtask

    task automatic set_kernel(input int rad, input kernel_style_t style);
        logic [CFG_DATA_W-1:0] lo, hi, rad_data;
        logic [TAP_W-1:0] t;
        int k, per;
        lo = {$urandom, $urandom};
        hi = {$urandom, $urandom};
        rad_data = {$urandom, $urandom};
        rad_data[RAD_W-1:0] = rad[RAD_W-1:0];
        per = 65536 / (2 * rad + 1);
        for (k = 0; k <= rad; k++) begin
            case (style)
                KERNEL_SMOOTH: t = (rad == 0) ? 16'hFFFF : 16'($urandom_range(per*3/4, per - 1));
                KERNEL_FULL:   t = 16'hFFFF;
                KERNEL_ZERO:   t = 16'h0000;
                default:       t = 16'($urandom);
            endcase
            if (k < 4) begin
                lo[16*k +: 16] = t;
            end else begin
                hi[16*(k-4) +: 16] = t;
            end
        end
        write_reg(CFG_RADIUS, rad_data);
        write_reg(CFG_COEF_LO, lo);
        write_reg(CFG_COEF_HI, hi);
    endtask

    function automatic logic [15:0] pick_pixel();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_coord(input int limit);
        if ($urandom_range(0, 1) == 0) begin
            return 8'($urandom_range(0, limit - 1));
        end
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic load_frame(input int w, input int h);
        int r, c;
        for (r = 0; r < h; r++) begin
            for (c = 0; c < w; c++) begin
                send_command(OP_LOAD, 8'(c), 8'(r), pick_pixel());
            end
        end
    endtask

    task automatic send_random_command(input int w, input int h);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 38) begin
            send_command(OP_LOAD, 8'($urandom_range(0, w - 1)), 8'($urandom_range(0, h - 1)),
                         pick_pixel());
        end else if (pick < 76) begin
            send_command(OP_READ, pick_coord(w), pick_coord(h), 16'($urandom));
        end else if (pick < 84) begin
            send_command(OP_RUN, 8'($urandom), 8'($urandom), 16'($urandom));
        end else if (pick < 95 && w < FRAME_STRIDE && $urandom_range(0, 1) == 0) begin
            send_command(OP_LOAD, 8'($urandom_range(w, 255)), 8'($urandom), pick_pixel());
        end else if (pick < 95 && h < DEF_MAX_HEIGHT) begin
            send_command(OP_LOAD, 8'($urandom), 8'($urandom_range(h, 255)), pick_pixel());
        end else begin
            send_command(OP_UNUSED, 8'($urandom), 8'($urandom), 16'($urandom));
        end
    endtask

    task automatic test_directed();
        logic [15:0] pixels [6];
        int i;
        pixels[0] = 16'h0000;
        pixels[1] = 16'hFFFF;
        pixels[2] = 16'h0001;
        pixels[3] = 16'h0003;
        pixels[4] = 16'h8001;
        pixels[5] = 16'($urandom);
        wait_drained(SETTLE_CYCLES);
        write_dim(CFG_WIDTH, 3);
        write_dim(CFG_HEIGHT, 2);
        for (i = 0; i < 6; i++) begin
            send_command(OP_LOAD, 8'(i % 3), 8'(i / 3), pixels[i]);
        end
        send_command(OP_LOAD, 8'd255, 8'd0, 16'hFFFF);
        send_command(OP_LOAD, 8'd0, 8'd255, 16'h0000);
        send_command(OP_UNUSED, 8'($urandom), 8'($urandom), 16'($urandom));
        send_command(OP_READ, 8'd0, 8'd0, 16'hFFFF);
        send_command(OP_READ, 8'd255, 8'd255, 16'h0000);
        send_command(OP_READ, 8'd255, 8'd0, 16'($urandom));
        // Kernel is still at its reset value here, so the run zeroes the frame.
        send_command(OP_RUN, 8'd0, 8'd0, 16'h0000);
        send_command(OP_READ, 8'd1, 8'd1, 16'h0000);
        wait_drained(SETTLE_CYCLES);
        write_reg(CFG_UNMAPPED, {$urandom, $urandom});
        write_reg(CFG_RADIUS, 64'd1);
        write_reg(CFG_COEF_LO, 64'h0000_0000_4000_8000);
        write_reg(CFG_COEF_HI, {$urandom, $urandom});
        for (i = 0; i < 6; i++) begin
            send_command(OP_LOAD, 8'(i % 3), 8'(i / 3), pixels[i]);
        end
        send_command(OP_RUN, 8'hFF, 8'hFF, 16'hFFFF);
        send_command(OP_READ, 8'd0, 8'd0, 16'h0000);
        send_command(OP_READ, 8'd2, 8'd1, 16'h0000);
        send_command(OP_READ, 8'd1, 8'd0, 16'h0000);
    endtask

    task automatic test_dimension_extremes();
        int i;
        wait_drained(SETTLE_CYCLES);
        write_dim(CFG_WIDTH, 0);
        write_dim(CFG_HEIGHT, 0);
        set_kernel(RADIUS_TOP, KERNEL_SMOOTH);
        send_command(OP_LOAD, 8'd0, 8'd0, pick_pixel());
        send_command(OP_LOAD, 8'd1, 8'd0, pick_pixel());
        send_command(OP_LOAD, 8'd0, 8'd1, pick_pixel());
        send_command(OP_READ, 8'd255, 8'd255, 16'h0000);
        send_command(OP_RUN, 8'd0, 8'd0, 16'h0000);
        send_command(OP_READ, 8'd0, 8'd0, 16'h0000);
        send_command(OP_READ, 8'd17, 8'd200, 16'h0000);

        wait_drained(SETTLE_CYCLES);
        write_dim(CFG_WIDTH, 256);
        write_dim(CFG_HEIGHT, 1);
        set_kernel(RADIUS_TOP, KERNEL_SMOOTH);
        load_frame(256, 1);
        send_command(OP_RUN, 8'($urandom), 8'($urandom), 16'($urandom));
        send_command(OP_READ, 8'd255, 8'd0, 16'h0000);
        for (i = 0; i < 4; i++) begin
            send_command(OP_READ, 8'($urandom), 8'($urandom), 16'($urandom));
        end

        wait_drained(SETTLE_CYCLES);
        write_dim(CFG_WIDTH, 511);
        set_kernel(3, KERNEL_FULL);
        send_command(OP_RUN, 8'($urandom), 8'($urandom), 16'($urandom));
        for (i = 0; i < 4; i++) begin
            send_command(OP_READ, 8'($urandom), 8'($urandom), 16'($urandom));
        end

        wait_drained(SETTLE_CYCLES);
        write_dim(CFG_WIDTH, 1);
        write_dim(CFG_HEIGHT, 511);
        set_kernel(RADIUS_TOP, KERNEL_RANDOM);
        load_frame(1, 256);
        send_command(OP_RUN, 8'($urandom), 8'($urandom), 16'($urandom));
        for (i = 0; i < 4; i++) begin
            send_command(OP_READ, 8'($urandom), 8'($urandom), 16'($urandom));
        end

        wait_drained(SETTLE_CYCLES);
        write_dim(CFG_HEIGHT, 256);
        set_kernel(0, KERNEL_SMOOTH);
        send_command(OP_RUN, 8'($urandom), 8'($urandom), 16'($urandom));
        send_command(OP_READ, 8'd0, 8'd255, 16'h0000);
        for (i = 0; i < 3; i++) begin
            send_command(OP_READ, 8'($urandom), 8'($urandom), 16'($urandom));
        end
    endtask

    task automatic test_output_backpressure();
        wait_drained(SETTLE_CYCLES);
        write_dim(CFG_WIDTH, 5);
        write_dim(CFG_HEIGHT, 5);
        set_kernel(2, KERNEL_SMOOTH);
        load_frame(5, 5);
        hold_requests++;
        send_command(OP_READ, 8'd1, 8'd2, 16'h0000);
        send_command(OP_READ, 8'd4, 8'd4, 16'h0000);
        repeat (40) send_random_command(5, 5);
        wait_drained(SETTLE_CYCLES);
    endtask

    task automatic test_random_frames();
        int w, h, pick;
        while (effective_items < ITEM_TARGET) begin
            wait_drained(SETTLE_CYCLES);
            pick = $urandom_range(0, 5);
            if (pick == 0) begin
                w = $urandom_range(1, 3);
                h = $urandom_range(16, 40);
            end else if (pick == 1) begin
                w = $urandom_range(16, 40);
                h = $urandom_range(1, 3);
            end else begin
                w = $urandom_range(1, 12);
                h = $urandom_range(1, 12);
            end
            write_dim(CFG_WIDTH, w);
            write_dim(CFG_HEIGHT, h);
            if ($urandom_range(0, 2) != 0) begin
                set_kernel($urandom_range(0, RADIUS_TOP), kernel_style_t'($urandom_range(0, 3)));
            end
            load_frame(w, h);
            repeat ($urandom_range(16, 48)) send_random_command(w, h);
            send_command(OP_RUN, 8'($urandom), 8'($urandom), 16'($urandom));
            repeat ($urandom_range(2, 8)) send_command(OP_READ, pick_coord(w), pick_coord(h),
                                                       16'($urandom));
        end
    endtask

    always @(negedge aclk) begin
        if (hold_requests != holds_served) begin
            holds_served++;
            hold_left = LONG_HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            if (stall_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(16, 160);
            end
            stall_left--;
            case (stall_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 3) != 0);
                2:       m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= stall_left[2];
            endcase
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (awaited_results.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected result, expected none, actual kind %0d value %h",
                         $time, m_tuser[0], m_tdata);
            end else begin
                oldest_result = awaited_results.pop_front();
                results_checked++;
                if (m_tuser[0] !== oldest_result.kind) begin
                    fail_count++;
                    $display("%0t: result kind mismatch, expected %0d, actual %0d",
                             $time, oldest_result.kind, m_tuser[0]);
                end
                if (m_tdata !== oldest_result.value) begin
                    fail_count++;
                    $display("%0t: filtered value mismatch, expected %h, actual %h",
                             $time, oldest_result.value, m_tdata);
                end
            end
        end
    end

    initial begin
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("%0t: timeout with %0d results outstanding", $time, awaited_results.size());
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_dimension_extremes();
        test_output_backpressure();
        test_random_frames();
        wait_drained(2 * SETTLE_CYCLES);
        $display("Sent %0d commands: %0d loads, %0d runs, %0d reads; %0d results checked.",
                 effective_items, loads_sent, runs_sent, reads_sent, results_checked);
        $display("Frames from 1x1 up to 256 wide and 256 tall, radius 0 to 7, with %s",
                 "zero, saturating and smooth kernels and long output stalls.");
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
